// ===== hw/rtl/nfba_pkg.sv =====
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants for the next-fit byte pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package nfba_pkg;

    localparam int POOL_BYTES   = 8192;
    localparam int HEADER_BYTES = 8;
    localparam int ALIGN_BYTES  = 8;
    localparam int GRANULES     = POOL_BYTES / ALIGN_BYTES;
    localparam int MIN_BLOCK    = HEADER_BYTES + ALIGN_BYTES;
    localparam int GW           = $clog2(GRANULES);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NO_FIT  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    localparam logic OPC_ALLOC = 1'b0;
    localparam logic OPC_FREE  = 1'b1;

    localparam logic REG_POOL_BYTES   = 1'b0;
    localparam logic REG_POOL_ENABLED = 1'b1;

    typedef struct packed {
        logic [GW-1:0] nxt;
        logic          start;
        logic          used;
    } entry_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_INIT_WALK,
        DP_RD_CUR,
        DP_STEP_NEXT,
        DP_TAKE_C,
        DP_RD_NX,
        DP_MERGE,
        DP_WSPLIT,
        DP_WCUR_KEEP,
        DP_WCUR_ALLOC,
        DP_RD_FREE,
        DP_FREE_COMMIT,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_req;
        logic clear_done;
        logic pool_ok;
        logic is_free;
        logic size_zero;
        logic oversize;
        logic visits_zero;
        logic rd_used;
        logic fit;
        logic split;
        logic free_null;
        logic free_pre_bad;
        logic free_entry_bad;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfba_datapath.sv =====
// ----------------------------------------------------------------------------
// nfba_datapath
// Block table memory, pool registers, walk pointers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_datapath (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_index,
    input  wire [13:0]          cfg_wr_data,
    input  wire                 s_opcode,
    input  wire [13:0]          s_request_size,
    input  wire [12:0]          s_free_address,
    input  nfba_pkg::dp_cmd_t   cmd,
    output nfba_pkg::dp_stat_t  stat,
    output logic [1:0]          m_status,
    output logic [12:0]         m_address,
    output logic [13:0]         m_available_bytes,
    output logic [10:0]         m_fragment_count
);

    localparam int GW = nfba_pkg::GW;

    nfba_pkg::entry_t mem [nfba_pkg::GRANULES];
    nfba_pkg::entry_t rdata_reg;

    logic [13:0]   pool_size_reg, pool_size_next;
    logic [GW-1:0] sent_g_reg, sent_g_next;
    logic          made_reg, made_next;
    logic          enabled_reg, enabled_next;
    logic [GW-1:0] search_reg, search_next;
    logic [13:0]   avail_reg, avail_next;
    logic [10:0]   frag_reg, frag_next;
    logic [GW-1:0] clr_reg, clr_next;

    logic          op_reg;
    logic [14:0]   size_reg;
    logic [12:0]   fa_reg;
    logic [GW-1:0] cur_reg, cur_next;
    logic [GW-1:0] nx_reg, nx_next;
    logic          cstart_reg, cstart_next;
    logic [11:0]   visits_reg, visits_next;

    // config decode
    logic [13:0] cfg_sz;
    logic        cfg_big;
    always_comb begin
        cfg_sz  = (cfg_wr_data > 14'(nfba_pkg::POOL_BYTES)) ?
                  14'(nfba_pkg::POOL_BYTES) : cfg_wr_data;
        cfg_sz  = {cfg_sz[13:3], 3'b000};
        cfg_big = cfg_sz >= 14'(2 * nfba_pkg::MIN_BLOCK);
    end
    logic cfg_pool_wr;
    assign cfg_pool_wr = cfg_wr_en && (cfg_index == nfba_pkg::REG_POOL_BYTES);

    // walk arithmetic, byte offsets
    logic [12:0] cur_b, nx_b;
    logic [13:0] room;
    logic [14:0] slack;
    logic [13:0] diff;
    logic [GW-1:0] sp_g;
    assign cur_b = {cur_reg, 3'b000};
    assign nx_b  = {nx_reg, 3'b000};
    assign room  = ({1'b0, nx_b} > ({1'b0, cur_b} + 14'(nfba_pkg::HEADER_BYTES))) ?
                   ({1'b0, nx_b} - {1'b0, cur_b} - 14'(nfba_pkg::HEADER_BYTES)) : 14'd0;
    assign slack = {1'b0, room} - size_reg;
    assign diff  = {1'b0, nx_b} - {1'b0, cur_b};
    assign sp_g  = cur_reg + GW'(1) + GW'(size_reg[14:3]);

    // free decode
    logic [12:0]   blk;
    logic [GW-1:0] blk_g;
    logic [12:0]   rd_next_b;
    assign blk       = fa_reg - 13'(nfba_pkg::HEADER_BYTES);
    assign blk_g     = blk[12:3];
    assign rd_next_b = {rdata_reg.nxt, 3'b000};

    // request size rounded up
    logic [14:0] size_rnd;
    assign size_rnd = ({1'b0, s_request_size} + 15'(nfba_pkg::ALIGN_BYTES - 1)) & ~15'd7;

    always_comb begin
        stat.clear_req      = cfg_pool_wr && cfg_big;
        stat.clear_done     = clr_reg == GW'(nfba_pkg::GRANULES - 1);
        stat.pool_ok        = made_reg && enabled_reg;
        stat.is_free        = op_reg == nfba_pkg::OPC_FREE;
        stat.size_zero      = size_reg == 15'd0;
        stat.oversize       = size_reg > {1'b0, avail_reg};
        stat.visits_zero    = visits_reg == 12'd0;
        stat.rd_used        = rdata_reg.used;
        stat.fit            = {1'b0, room} >= size_reg;
        stat.split          = slack >= 15'(nfba_pkg::MIN_BLOCK);
        stat.free_null      = fa_reg == 13'd0;
        stat.free_pre_bad   = (fa_reg < 13'(nfba_pkg::HEADER_BYTES)) || (blk[2:0] != 3'd0)
                              || ({1'b0, fa_reg} >= pool_size_reg);
        stat.free_entry_bad = !rdata_reg.start || !rdata_reg.used || (rd_next_b <= blk);
    end

    // memory port control
    logic             we, re;
    logic [GW-1:0]    waddr, raddr;
    nfba_pkg::entry_t wdata;

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = cur_reg;
        raddr = cur_reg;
        wdata = '{nxt: nx_reg, start: cstart_reg, used: 1'b0};
        case (cmd.op)
            nfba_pkg::DP_CLEAR: begin
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == '0)
                    wdata = '{nxt: sent_g_reg, start: 1'b1, used: 1'b0};
                else if (clr_reg == sent_g_reg)
                    wdata = '{nxt: '0, start: 1'b1, used: 1'b1};
                else
                    wdata = '0;
            end
            nfba_pkg::DP_RD_CUR:  re = 1'b1;
            nfba_pkg::DP_RD_NX: begin
                re    = 1'b1;
                raddr = nx_reg;
            end
            nfba_pkg::DP_RD_FREE: begin
                re    = 1'b1;
                raddr = blk_g;
            end
            nfba_pkg::DP_MERGE: begin
                // absorbed neighbor loses its block-start mark
                we    = 1'b1;
                waddr = nx_reg;
                wdata = '{nxt: rdata_reg.nxt, start: 1'b0, used: 1'b0};
            end
            nfba_pkg::DP_WSPLIT: begin
                we    = 1'b1;
                waddr = sp_g;
                wdata = '{nxt: nx_reg, start: 1'b1, used: 1'b0};
            end
            nfba_pkg::DP_WCUR_KEEP: we = 1'b1;
            nfba_pkg::DP_WCUR_ALLOC: begin
                we    = 1'b1;
                wdata = '{nxt: nx_reg, start: cstart_reg, used: 1'b1};
            end
            nfba_pkg::DP_FREE_COMMIT: begin
                we    = 1'b1;
                waddr = blk_g;
                wdata = '{nxt: rdata_reg.nxt, start: rdata_reg.start, used: 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // register updates
    always_comb begin
        pool_size_next = pool_size_reg;
        sent_g_next    = sent_g_reg;
        made_next      = made_reg;
        enabled_next   = enabled_reg;
        search_next    = search_reg;
        avail_next     = avail_reg;
        frag_next      = frag_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        cstart_next    = cstart_reg;
        visits_next    = visits_reg;

        case (cmd.op)
            nfba_pkg::DP_CLEAR:     clr_next = clr_reg + GW'(1);
            nfba_pkg::DP_INIT_WALK: begin
                cur_next    = search_reg;
                visits_next = {1'b0, frag_reg} + 12'd1;
            end
            nfba_pkg::DP_RD_CUR:    visits_next = visits_reg - 12'd1;
            nfba_pkg::DP_STEP_NEXT: cur_next = rdata_reg.nxt;
            nfba_pkg::DP_TAKE_C: begin
                nx_next     = rdata_reg.nxt;
                cstart_next = rdata_reg.start;
            end
            nfba_pkg::DP_MERGE: begin
                nx_next = rdata_reg.nxt;
                if (frag_reg != 11'd0)
                    frag_next = frag_reg - 11'd1;
            end
            nfba_pkg::DP_WSPLIT: begin
                nx_next   = sp_g;
                frag_next = frag_reg + 11'd1;
            end
            nfba_pkg::DP_WCUR_KEEP: cur_next = nx_reg;
            nfba_pkg::DP_WCUR_ALLOC: begin
                if (nx_b >= cur_b && diff <= avail_reg)
                    avail_next = avail_reg - diff;
                else
                    avail_next = '0;
                if (frag_reg != 11'd0)
                    frag_next = frag_reg - 11'd1;
                search_next = nx_reg;
            end
            nfba_pkg::DP_FREE_COMMIT: begin
                avail_next = avail_reg + 14'(rd_next_b - blk);
                frag_next  = frag_reg + 11'd1;
                if (blk_g < search_reg)
                    search_next = blk_g;
            end
            default: ;
        endcase

        if (cfg_wr_en) begin
            if (cfg_index == nfba_pkg::REG_POOL_BYTES) begin
                if (cfg_big) begin
                    pool_size_next = cfg_sz;
                    sent_g_next    = GW'(cfg_sz[13:3] - 11'd1);
                    search_next    = '0;
                    avail_next     = cfg_sz - 14'(2 * nfba_pkg::HEADER_BYTES);
                    frag_next      = 11'd1;
                    clr_next       = '0;
                    made_next      = 1'b1;
                    enabled_next   = 1'b1;
                end else begin
                    made_next    = 1'b0;
                    enabled_next = 1'b0;
                end
            end else begin
                enabled_next = cfg_wr_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= 14'(nfba_pkg::POOL_BYTES);
            sent_g_reg    <= GW'(nfba_pkg::GRANULES - 1);
            made_reg      <= 1'b1;
            enabled_reg   <= 1'b1;
            search_reg    <= '0;
            avail_reg     <= 14'(nfba_pkg::POOL_BYTES - 2 * nfba_pkg::HEADER_BYTES);
            frag_reg      <= 11'd1;
            clr_reg       <= '0;
        end else begin
            pool_size_reg <= pool_size_next;
            sent_g_reg    <= sent_g_next;
            made_reg      <= made_next;
            enabled_reg   <= enabled_next;
            search_reg    <= search_next;
            avail_reg     <= avail_next;
            frag_reg      <= frag_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        nx_reg     <= nx_next;
        cstart_reg <= cstart_next;
        visits_reg <= visits_next;
        if (cmd.op == nfba_pkg::DP_LOAD) begin
            op_reg   <= s_opcode;
            size_reg <= size_rnd;
            fa_reg   <= s_free_address;
        end
        if (cmd.op == nfba_pkg::DP_RESULT) begin
            m_status          <= cmd.status;
            m_address         <= (cmd.status == nfba_pkg::ST_OK && !stat.is_free) ?
                                 cur_b + 13'(nfba_pkg::HEADER_BYTES) : 13'd0;
            m_available_bytes <= avail_reg;
            m_fragment_count  <= frag_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfba_ctrl
// Sequencer for table clearing, allocate walks, frees and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module nfba_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    input  nfba_pkg::dp_stat_t  stat,
    output nfba_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECIDE, S_A_RD, S_A_EVAL, S_M_RD, S_M_EVAL,
        S_C_DEC, S_A_WCUR, S_F_EVAL, S_FIN
    } state_t;

    state_t              state_reg, state_next;
    nfba_pkg::status_t   status_reg, status_next;
    logic                m_valid_reg;
    logic                m_valid_next;

    assign s_ready    = state_reg == S_IDLE;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = nfba_pkg::DP_NOP;
        cmd.status   = status_reg;

        case (state_reg)
            S_CLEAR: begin
                cmd.op = nfba_pkg::DP_CLEAR;
                if (stat.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = nfba_pkg::DP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_FIN;
                if (!stat.pool_ok)
                    status_next = nfba_pkg::ST_INVALID;
                else if (!stat.is_free) begin
                    if (stat.size_zero)
                        status_next = nfba_pkg::ST_NULL;
                    else if (stat.oversize)
                        status_next = nfba_pkg::ST_NO_FIT;
                    else begin
                        cmd.op     = nfba_pkg::DP_INIT_WALK;
                        state_next = S_A_RD;
                    end
                end else begin
                    if (stat.free_null)
                        status_next = nfba_pkg::ST_NULL;
                    else if (stat.free_pre_bad)
                        status_next = nfba_pkg::ST_INVALID;
                    else begin
                        cmd.op     = nfba_pkg::DP_RD_FREE;
                        state_next = S_F_EVAL;
                    end
                end
            end
            S_A_RD: begin
                if (stat.visits_zero) begin
                    status_next = nfba_pkg::ST_NO_FIT;
                    state_next  = S_FIN;
                end else begin
                    cmd.op     = nfba_pkg::DP_RD_CUR;
                    state_next = S_A_EVAL;
                end
            end
            S_A_EVAL: begin
                if (stat.rd_used) begin
                    cmd.op     = nfba_pkg::DP_STEP_NEXT;
                    state_next = S_A_RD;
                end else begin
                    cmd.op     = nfba_pkg::DP_TAKE_C;
                    state_next = S_M_RD;
                end
            end
            S_M_RD: begin
                cmd.op     = nfba_pkg::DP_RD_NX;
                state_next = S_M_EVAL;
            end
            S_M_EVAL: begin
                if (!stat.rd_used) begin
                    cmd.op     = nfba_pkg::DP_MERGE;
                    state_next = S_M_RD;
                end else
                    state_next = S_C_DEC;
            end
            S_C_DEC: begin
                if (stat.fit) begin
                    if (stat.split)
                        cmd.op = nfba_pkg::DP_WSPLIT;
                    state_next = S_A_WCUR;
                end else begin
                    // write back the merged link and move on
                    cmd.op     = nfba_pkg::DP_WCUR_KEEP;
                    state_next = S_A_RD;
                end
            end
            S_A_WCUR: begin
                cmd.op      = nfba_pkg::DP_WCUR_ALLOC;
                status_next = nfba_pkg::ST_OK;
                state_next  = S_FIN;
            end
            S_F_EVAL: begin
                state_next = S_FIN;
                if (stat.free_entry_bad)
                    status_next = nfba_pkg::ST_INVALID;
                else begin
                    cmd.op      = nfba_pkg::DP_FREE_COMMIT;
                    status_next = nfba_pkg::ST_OK;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = nfba_pkg::DP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (stat.clear_req)
            state_next = S_CLEAR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            status_reg  <= nfba_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/next_fit_byte_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// next_fit_byte_pool_allocator
// Byte-pool allocator with a next-fit walk over an address-ordered block table.
// ----------------------------------------------------------------------------
// After reset, and after every write of a valid pool size, the block table is
// swept one entry per cycle and no request is taken meanwhile.
// A request is handled one at a time from a single-port table read per cycle.
// A rejected request passes the accept, decision and result states, and a free
// also reads and checks its block entry. An allocate reads and checks each
// visited block, reads the next neighbor of each free block examined, merges
// each free neighbor, and ends with the final write-back of the chosen block.
// The result sits in an output register, so the next transfer is taken while
// it waits.
`default_nettype none

module next_fit_byte_pool_allocator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire [13:0]  cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire [13:0]  s_request_size,
    input  wire [12:0]  s_free_address,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [12:0] m_address,
    output logic [13:0] m_available_bytes,
    output logic [10:0] m_fragment_count
);

    nfba_pkg::dp_cmd_t  cmd;
    nfba_pkg::dp_stat_t stat;

    nfba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nfba_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_opcode          (s_opcode),
        .s_request_size    (s_request_size),
        .s_free_address    (s_free_address),
        .cmd               (cmd),
        .stat              (stat),
        .m_status          (m_status),
        .m_address         (m_address),
        .m_available_bytes (m_available_bytes),
        .m_fragment_count  (m_fragment_count)
    );

endmodule

`default_nettype wire

// ===== bench/tb_next_fit_byte_pool_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_fit_byte_pool_allocator
// Self-checking bench: a shadow block table predicts every result, and the
// results are compared field by field in transfer order. Covers directed corner
// requests, random alloc/free traffic over several pool sizes and idle mixes,
// and an output stall long enough to back up the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_next_fit_byte_pool_allocator;

    localparam int TBL = 1024;

    typedef struct {
        nfba_pkg::status_t status;
        logic [12:0]       address;
        logic [13:0]       avail;
        logic [10:0]       frags;
    } alloc_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [13:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [13:0] s_request_size;
    logic [12:0] s_free_address;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [12:0] m_address;
    logic [13:0] m_available_bytes;
    logic [10:0] m_fragment_count;

    next_fit_byte_pool_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_request_size(s_request_size), .s_free_address(s_free_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_address(m_address), .m_available_bytes(m_available_bytes),
        .m_fragment_count(m_fragment_count)
    );

    // shadow pool state
    int unsigned blk_next_sh[TBL];
    bit          blk_start_sh[TBL];
    bit          blk_used_sh[TBL];
    int unsigned pool_cfg_bytes;
    bit          pool_en_sh;
    bit          pool_made_sh;
    int unsigned pool_size_sh;
    int unsigned rover_gran;
    int unsigned avail_sh;
    int unsigned frags_sh;

    alloc_result_t expected_results[$];
    logic [12:0]   live_blocks[$];
    int            mismatches;
    int            send_idle;
    int            recv_idle;
    int            stall_left;

    function automatic int unsigned gran(int unsigned off);
        return (off / nfba_pkg::ALIGN_BYTES) % TBL;
    endfunction

    function automatic void rebuild_pool();
        int unsigned sz;
        int unsigned sent;
        sz = pool_cfg_bytes;
        if (sz > nfba_pkg::POOL_BYTES) sz = nfba_pkg::POOL_BYTES;
        sz = (sz / nfba_pkg::ALIGN_BYTES) * nfba_pkg::ALIGN_BYTES;
        if (sz < 2 * nfba_pkg::MIN_BLOCK) begin
            pool_made_sh = 0;
            pool_en_sh = 0;
            return;
        end
        for (int i = 0; i < TBL; i++) begin
            blk_next_sh[i] = 0;
            blk_start_sh[i] = 0;
            blk_used_sh[i] = 0;
        end
        pool_size_sh = sz;
        sent = sz - nfba_pkg::HEADER_BYTES;
        blk_next_sh[0] = sent;
        blk_start_sh[0] = 1;
        blk_next_sh[gran(sent)] = 0;
        blk_start_sh[gran(sent)] = 1;
        blk_used_sh[gran(sent)] = 1;
        rover_gran = 0;
        avail_sh = sz - 2 * nfba_pkg::HEADER_BYTES;
        frags_sh = 1;
        pool_made_sh = 1;
        pool_en_sh = 1;
    endfunction

    function automatic nfba_pkg::status_t walk_alloc(int unsigned req,
                                                     output int unsigned addr);
        int unsigned size, cur, visits, guard, c, nx, mg, room, sp;
        size = ((req + nfba_pkg::ALIGN_BYTES - 1) / nfba_pkg::ALIGN_BYTES)
               * nfba_pkg::ALIGN_BYTES;
        cur = rover_gran * nfba_pkg::ALIGN_BYTES;
        visits = frags_sh + 1;
        guard = TBL + 2;
        addr = 0;
        if (size > avail_sh) return nfba_pkg::ST_NO_FIT;
        while (visits > 0 && guard > 0) begin
            c = gran(cur);
            visits--;
            guard--;
            if (!blk_used_sh[c]) begin
                nx = blk_next_sh[c];
                mg = TBL;
                // lazy merge of free neighbors
                while (!blk_used_sh[gran(nx)] && mg > 0) begin
                    blk_next_sh[c] = blk_next_sh[gran(nx)];
                    blk_start_sh[gran(nx)] = 0;
                    if (frags_sh > 0) frags_sh--;
                    nx = blk_next_sh[c];
                    mg--;
                end
                room = (nx > cur + nfba_pkg::HEADER_BYTES) ?
                       nx - cur - nfba_pkg::HEADER_BYTES : 0;
                if (room >= size) begin
                    if (room - size >= nfba_pkg::MIN_BLOCK) begin
                        sp = cur + nfba_pkg::HEADER_BYTES + size;
                        blk_next_sh[gran(sp)] = nx;
                        blk_start_sh[gran(sp)] = 1;
                        blk_used_sh[gran(sp)] = 0;
                        blk_next_sh[c] = sp;
                        frags_sh++;
                    end
                    blk_used_sh[c] = 1;
                    nx = blk_next_sh[c];
                    avail_sh -= (nx - cur <= avail_sh) ? nx - cur : avail_sh;
                    if (frags_sh > 0) frags_sh--;
                    rover_gran = gran(nx);
                    addr = cur + nfba_pkg::HEADER_BYTES;
                    return nfba_pkg::ST_OK;
                end
            end
            cur = blk_next_sh[c];
        end
        return nfba_pkg::ST_NO_FIT;
    endfunction

    function automatic nfba_pkg::status_t release_block(int unsigned fa);
        int unsigned blk, g;
        if (fa == 0) return nfba_pkg::ST_NULL;
        if (fa < nfba_pkg::HEADER_BYTES) return nfba_pkg::ST_INVALID;
        blk = fa - nfba_pkg::HEADER_BYTES;
        if (blk % nfba_pkg::ALIGN_BYTES != 0 || blk + nfba_pkg::HEADER_BYTES >= pool_size_sh)
            return nfba_pkg::ST_INVALID;
        g = gran(blk);
        if (!blk_start_sh[g] || !blk_used_sh[g] || blk_next_sh[g] <= blk)
            return nfba_pkg::ST_INVALID;
        avail_sh += blk_next_sh[g] - blk;
        frags_sh++;
        blk_used_sh[g] = 0;
        if (g < rover_gran) rover_gran = g;
        return nfba_pkg::ST_OK;
    endfunction

    function automatic void predict_result(logic op, logic [13:0] req, logic [12:0] fa);
        alloc_result_t r;
        int unsigned a;
        a = 0;
        if (!pool_made_sh || !pool_en_sh) r.status = nfba_pkg::ST_INVALID;
        else if (op == nfba_pkg::OPC_ALLOC)
            r.status = (req == 0) ? nfba_pkg::ST_NULL : walk_alloc(req, a);
        else r.status = release_block(fa);
        if (op == nfba_pkg::OPC_ALLOC && r.status == nfba_pkg::ST_OK)
            live_blocks.push_back(a[12:0]);
        r.address = a[12:0];
        r.avail = avail_sh[13:0];
        r.frags = frags_sh[10:0];
        expected_results.push_back(r);
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random idling plus an explicit long stall
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result checker; transfer happens at the following rising edge
    always @(negedge aclk) begin
        alloc_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                e = expected_results.pop_front();
                if (m_status !== e.status || m_address !== e.address
                    || m_available_bytes !== e.avail || m_fragment_count !== e.frags) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp st=%0d a=%0d av=%0d fr=%0d got st=%0d a=%0d av=%0d fr=%0d",
                                 e.status, e.address, e.avail, e.frags, m_status, m_address,
                                 m_available_bytes, m_fragment_count);
                end
            end
        end
    end

    task automatic send_item(logic op, logic [13:0] req, logic [12:0] fa);
        bit done;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_request_size <= req;
        s_free_address <= fa;
        done = 0;
        while (!done) begin
            @(negedge aclk);
            if (s_ready) begin
                predict_result(op, req, fa);
                done = 1;
            end
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [13:0] val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == nfba_pkg::REG_POOL_BYTES) begin
            pool_cfg_bytes = val;
            rebuild_pool();
            live_blocks.delete();
        end else begin
            pool_en_sh = val[0];
        end
    endtask

    task automatic test_directed();
        send_item(nfba_pkg::OPC_ALLOC, 14'd0, 13'd0);          // zero size
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd0);           // null pointer
        send_item(nfba_pkg::OPC_ALLOC, 14'd16383, 13'd0);      // oversize
        send_item(nfba_pkg::OPC_ALLOC, 14'd1, 13'd0);
        send_item(nfba_pkg::OPC_ALLOC, 14'd8, 13'd0);
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd3);           // below header
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd13);          // misaligned
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8191);
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd24);          // second allocated block
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8);
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8);           // double free
        send_item(nfba_pkg::OPC_ALLOC, 14'd8160, 13'd0);       // fits after merge, with a split
        send_item(nfba_pkg::OPC_ALLOC, 14'd8168, 13'd0);       // no fit
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8184);        // sentinel area
        write_reg(nfba_pkg::REG_POOL_ENABLED, 14'd0);
        send_item(nfba_pkg::OPC_ALLOC, 14'd8, 13'd0);
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8);
        write_reg(nfba_pkg::REG_POOL_ENABLED, 14'd1);
        send_item(nfba_pkg::OPC_FREE, 14'd0, 13'd8);
        write_reg(nfba_pkg::REG_POOL_BYTES, 14'd24);           // too small, pool not made
        send_item(nfba_pkg::OPC_ALLOC, 14'd8, 13'd0);
        write_reg(nfba_pkg::REG_POOL_ENABLED, 14'd1);
        send_item(nfba_pkg::OPC_ALLOC, 14'd8, 13'd0);
        write_reg(nfba_pkg::REG_POOL_BYTES, 14'd39);           // rounds to minimum
        send_item(nfba_pkg::OPC_ALLOC, 14'd8, 13'd0);
        send_item(nfba_pkg::OPC_ALLOC, 14'd1, 13'd0);
        write_reg(nfba_pkg::REG_POOL_BYTES, 14'd16383);        // clamped to full pool
        send_item(nfba_pkg::OPC_ALLOC, 14'd8176, 13'd0);
        send_item(nfba_pkg::OPC_ALLOC, 14'd1, 13'd0);
    endtask

    task automatic random_item(int unsigned max_req);
        int k;
        int unsigned pick;
        logic [12:0] a;
        pick = $urandom_range(99);
        if (pick < 48) begin
            send_item(nfba_pkg::OPC_ALLOC, 14'($urandom_range(max_req, 1)), 13'($urandom));
        end else if (pick < 88 && live_blocks.size() != 0) begin
            k = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            send_item(nfba_pkg::OPC_FREE, 14'($urandom), a);
        end else if (pick < 93) begin
            send_item(nfba_pkg::OPC_FREE, 14'($urandom), 13'($urandom));
        end else if (pick < 96) begin
            send_item(nfba_pkg::OPC_ALLOC, 14'($urandom), 13'($urandom));
        end else if (pick < 98) begin
            send_item(nfba_pkg::OPC_ALLOC, 14'd0, 13'($urandom));
        end else begin
            send_item(nfba_pkg::OPC_FREE, 14'($urandom), 13'd0);
        end
    endtask

    task automatic test_random_phase(int s_idle, int r_idle);
        int unsigned sizes[5] = '{32, 200, 1024, 8192, 0};
        int unsigned sz;
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int seg = 0; seg < 5; seg++) begin
            sz = (seg == 4) ? $urandom_range(16383, 32) : sizes[(seg + s_idle) % 4];
            write_reg(nfba_pkg::REG_POOL_BYTES, 14'(sz));
            if ($urandom_range(5) == 0)
                write_reg(nfba_pkg::REG_POOL_ENABLED, 14'($urandom_range(1)));
            for (int i = 0; i < 120; i++) random_item((sz > 2048) ? 300 : sz / 2);
            write_reg(nfba_pkg::REG_POOL_ENABLED, 14'd1);
        end
    endtask

    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        write_reg(nfba_pkg::REG_POOL_BYTES, 14'd8192);
        stall_left = 400;
        for (int i = 0; i < 40; i++)
            send_item(nfba_pkg::OPC_ALLOC, 14'($urandom_range(64, 1)), 13'd0);
        drain_results();
        for (int i = 0; i < 40; i++) random_item(128);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_opcode = 1'b0;
        s_request_size = '0;
        s_free_address = '0;
        m_ready = 1'b0;
        mismatches = 0;
        stall_left = 0;
        send_idle = 16;
        recv_idle = 68;
        pool_cfg_bytes = 8192;
        rebuild_pool();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(16, 68);
        test_random_phase(68, 16);
        test_random_phase(0, 0);
        test_backpressure();

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
